// ----- design/dsqts_pkg.sv -----
package dsqts_pkg;

   // Input item fields
   typedef struct packed {
      logic [1:0] op;
      logic [2:0] target_one;
      logic [2:0] target_two;
      logic       clear_tracking;
   } req_type;

   // Result item fields
   typedef struct packed {
      logic [3:0] coils_one;
      logic [3:0] coils_two;
      logic       busy_res;
      logic [1:0] position_one;
      logic [1:0] position_two;
      logic [1:0] status;
   } rsp_type;

   // Configuration register set
   typedef struct packed {
      logic [12:0] steps_per_quarter;
      logic [7:0]  step_ticks;
      logic        reverse_sequence_two;
      logic        reverse_pins_two;
      logic [1:0]  park_position;
   } cfg_type;

   // Operation codes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_MOVE_BOTH = 2'd1;
   localparam logic [1:0] OP_MOVE_ONE  = 2'd2;
   localparam logic [1:0] OP_MOVE_TWO  = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_BUSY  = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_QUARTER    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_TICKS           = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_SEQUENCE_TWO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_PINS_TWO     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARK_POSITION        = 3'd4;

   // Configuration reset values
   localparam logic [12:0] SPQ_RESET        = 13'd1024;
   localparam logic [7:0]  STEP_TICKS_RESET = 8'd2;

   // Half-step coil pattern for one phase
   function automatic logic [3:0] half_step(input logic [2:0] idx);
      logic [3:0] c;
      case (idx)
         3'd0: c = 4'h1;
         3'd1: c = 4'h3;
         3'd2: c = 4'h2;
         3'd3: c = 4'h6;
         3'd4: c = 4'h4;
         3'd5: c = 4'hC;
         3'd6: c = 4'h8;
         3'd7: c = 4'h9;
         default: c = 4'h0;
      endcase
      return c;
   endfunction

   // Swap coil order IN1..IN4 to IN4..IN1
   function automatic logic [3:0] rev_nibble(input logic [3:0] v);
      return {v[0], v[1], v[2], v[3]};
   endfunction

endpackage

// ----- design/dual_stepper_quarter_turn_sequencer.sv -----
// A req transfer reaches its rsp through the input register and then the result register.
// Throughput: one item per cycle while rsp_stall is low; the motor state update is a single pass of
// logic between the input register and the result register.
// Reset (synchronous, active high): registers back to defaults, positions at
// zero, coils off, not moving, both channels empty.
module dual_stepper_quarter_turn_sequencer #(
   parameter int MAX_STEPS_PER_QUARTER = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dsqts_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dsqts_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [dsqts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsqts_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dsqts_pkg::*;

   cfg_type cfg;
   logic    item_valid;
   req_type item;
   logic    item_take;

   dsqts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dsqts_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   dsqts_engine #(
      .MAX_STEPS_PER_QUARTER (MAX_STEPS_PER_QUARTER)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // A rejected-while-busy result always reports the move still running
   a_busy_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_BUSY) |-> rsp_data.busy_res)
      else $error("busy status without busy flag");

   // Coils are off whenever no move is running
   a_idle_coils: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.busy_res) |->
      (rsp_data.coils_one == 4'h0 && rsp_data.coils_two == 4'h0))
      else $error("coils driven while idle");

   // Nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ----- design/dsqts_csr.sv -----
module dsqts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dsqts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsqts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dsqts_pkg::cfg_type               cfg
);
   import dsqts_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEPS_PER_QUARTER:    cfg_in.steps_per_quarter = csr_wdata[12:0];
            CSR_STEP_TICKS:           cfg_in.step_ticks = csr_wdata[7:0];
            CSR_REVERSE_SEQUENCE_TWO: cfg_in.reverse_sequence_two = csr_wdata[0];
            CSR_REVERSE_PINS_TWO:     cfg_in.reverse_pins_two = csr_wdata[0];
            CSR_PARK_POSITION:        cfg_in.park_position = csr_wdata[1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_quarter    <= SPQ_RESET;
         cfg_ff.step_ticks           <= STEP_TICKS_RESET;
         cfg_ff.reverse_sequence_two <= 1'b0;
         cfg_ff.reverse_pins_two     <= 1'b0;
         cfg_ff.park_position        <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/dsqts_in_stage.sv -----
module dsqts_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dsqts_pkg::req_type req_data,
   output logic               item_valid,
   output dsqts_pkg::req_type item,
   input  logic               item_take
);
   import dsqts_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    load;

   // Refill when empty or when the held item moves on this cycle
   assign load      = req_valid && (!valid_ff || item_take);
   assign req_stall = valid_ff && !item_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- design/dsqts_engine.sv -----
module dsqts_engine #(
   parameter int MAX_STEPS_PER_QUARTER = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  dsqts_pkg::cfg_type cfg,
   input  logic               item_valid,
   input  dsqts_pkg::req_type item,
   output logic               item_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dsqts_pkg::rsp_type rsp_data
);
   import dsqts_pkg::*;

   localparam int LW       = $clog2(3 * MAX_STEPS_PER_QUARTER + 1);
   localparam int SPQ_CAPV = (MAX_STEPS_PER_QUARTER > 8191) ? 8191 : MAX_STEPS_PER_QUARTER;
   localparam logic [12:0] SPQ_CAP = 13'(SPQ_CAPV);

   // Motor tracking state
   logic [1:0]    pos_one_ff, pos_one_in, pos_two_ff, pos_two_in;
   logic [2:0]    phase_one_ff, phase_one_in, phase_two_ff, phase_two_in;
   logic [LW-1:0] left_one_ff, left_one_in, left_two_ff, left_two_in;
   logic [1:0]    pend_one_ff, pend_one_in, pend_two_ff, pend_two_in;
   logic [7:0]    wait_ff, wait_in;
   logic          moving_ff, moving_in;
   logic [7:0]    coil_ff, coil_in;
   logic [1:0]    status;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic          do_one, do_two;
   logic [12:0]   spq_sat;
   logic [1:0]    dist_one, dist_two;
   logic [LW-1:0] steps_one, steps_two;
   logic [3:0]    coil_two;

   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);

   // Forward distance times steps per quarter, as two shifted adds
   assign spq_sat  = (32'(cfg.steps_per_quarter) > 32'(SPQ_CAPV)) ? SPQ_CAP
                                                                   : cfg.steps_per_quarter;
   assign dist_one = item.target_one[1:0] - pos_one_ff;
   assign dist_two = item.target_two[1:0] - pos_two_ff;
   assign steps_one = (dist_one[0] ? LW'(spq_sat) : '0)
                    + (dist_one[1] ? LW'({spq_sat, 1'b0}) : '0);
   assign steps_two = (dist_two[0] ? LW'(spq_sat) : '0)
                    + (dist_two[1] ? LW'({spq_sat, 1'b0}) : '0);

   assign do_one = (item.op == OP_MOVE_BOTH) || (item.op == OP_MOVE_ONE);
   assign do_two = (item.op == OP_MOVE_BOTH) || (item.op == OP_MOVE_TWO);

   // Motor two pattern with optional sequence and pin reversal
   always_comb begin
      coil_two = half_step(cfg.reverse_sequence_two ? ~phase_two_ff : phase_two_ff);
      if (cfg.reverse_pins_two) begin
         coil_two = rev_nibble(coil_two);
      end
   end

   // Next state for one item
   always_comb begin
      pos_one_in   = pos_one_ff;
      pos_two_in   = pos_two_ff;
      phase_one_in = phase_one_ff;
      phase_two_in = phase_two_ff;
      left_one_in  = left_one_ff;
      left_two_in  = left_two_ff;
      pend_one_in  = pend_one_ff;
      pend_two_in  = pend_two_ff;
      wait_in      = wait_ff;
      moving_in    = moving_ff;
      coil_in      = coil_ff;
      status       = STATUS_OK;

      if (item.op == OP_TICK) begin
         if (item.clear_tracking) begin
            // Abort and return tracking to home
            pos_one_in   = cfg.park_position;
            pos_two_in   = cfg.park_position;
            phase_one_in = '0;
            phase_two_in = '0;
            pend_one_in  = '0;
            pend_two_in  = '0;
            left_one_in  = '0;
            left_two_in  = '0;
            wait_in      = '0;
            moving_in    = 1'b0;
            coil_in      = '0;
         end else if (moving_ff) begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 8'd1;
            end else if (left_one_ff != '0 || left_two_ff != '0) begin
               // Advance each motor that still has steps
               if (left_one_ff != '0) begin
                  coil_in[3:0] = half_step(phase_one_ff);
                  phase_one_in = phase_one_ff + 3'd1;
                  left_one_in  = left_one_ff - LW'(1);
               end
               if (left_two_ff != '0) begin
                  coil_in[7:4] = coil_two;
                  phase_two_in = phase_two_ff + 3'd1;
                  left_two_in  = left_two_ff - LW'(1);
               end
               wait_in = cfg.step_ticks;
            end else begin
               // Settle positions and drop the coils
               pos_one_in = pend_one_ff;
               pos_two_in = pend_two_ff;
               coil_in    = '0;
               moving_in  = 1'b0;
               left_one_in = '0;
               left_two_in = '0;
               wait_in     = '0;
            end
         end
      end else if (moving_ff) begin
         status = STATUS_BUSY;
      end else if ((do_one && item.target_one[2]) || (do_two && item.target_two[2])) begin
         status = STATUS_RANGE;
      end else begin
         pend_one_in = do_one ? item.target_one[1:0] : pos_one_ff;
         pend_two_in = do_two ? item.target_two[1:0] : pos_two_ff;
         left_one_in = do_one ? steps_one : '0;
         left_two_in = do_two ? steps_two : '0;
         wait_in     = '0;
         if (left_one_in == '0 && left_two_in == '0) begin
            // Nothing to travel: settle at once
            pos_one_in = pend_one_in;
            pos_two_in = pend_two_in;
            coil_in    = '0;
            moving_in  = 1'b0;
         end else begin
            moving_in = 1'b1;
         end
      end

      rsp_in.coils_one    = coil_in[3:0];
      rsp_in.coils_two    = coil_in[7:4];
      rsp_in.busy_res     = moving_in;
      rsp_in.position_one = pos_one_in;
      rsp_in.position_two = pos_two_in;
      rsp_in.status       = status;
   end

   // Output valid: set on a transfer in, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_one_ff   <= 2'd0;
         pos_two_ff   <= 2'd0;
         phase_one_ff <= '0;
         phase_two_ff <= '0;
         left_one_ff  <= '0;
         left_two_ff  <= '0;
         pend_one_ff  <= '0;
         pend_two_ff  <= '0;
         wait_ff      <= '0;
         moving_ff    <= 1'b0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            pos_one_ff   <= pos_one_in;
            pos_two_ff   <= pos_two_in;
            phase_one_ff <= phase_one_in;
            phase_two_ff <= phase_two_in;
            left_one_ff  <= left_one_in;
            left_two_ff  <= left_two_in;
            pend_one_ff  <= pend_one_in;
            pend_two_ff  <= pend_two_in;
            wait_ff      <= wait_in;
            moving_ff    <= moving_in;
            coil_ff      <= coil_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
